[design/ftpt_pkg.sv]
// Package for the frame table packet trigger extractor.
// Holds the constants, status and state codes and the queue entry type.
// No dependencies.
package ftpt_pkg;

  localparam int unsigned MAX_FRAMES_DEF       = 256;
  localparam int unsigned MAX_PACKET_WORDS_DEF = 16 * 1024 * 1024;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PW_W    = 25;
  localparam int unsigned NFW_W   = 27;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned VAL_W   = 17;

  localparam logic [31:0] MAGIC_BE = 32'hCAFE_BABE;
  localparam logic [31:0] MAGIC_LE = 32'hBEBA_FECA;
  localparam logic [3:0]  TYPE_START_A = 4'h3;
  localparam logic [3:0]  TYPE_START_B = 4'hB;
  localparam logic [3:0]  TYPE_HLT     = 4'hE;
  localparam logic [VAL_W-1:0] NOT_SEEN = 17'h1_0000;

  typedef enum logic [2:0] {
    STAT_FOUND   = 3'd0,
    STAT_NONE    = 3'd1,
    STAT_BAD_SZ  = 3'd2,
    STAT_BAD_MAG = 3'd3,
    STAT_BAD_CNT = 3'd4,
    STAT_BAD_LEN = 3'd5,
    STAT_OVERRUN = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_RD,
    BK_CHK
  } back_state_t;

  // one queue word: packet word plus its position as worked out in front
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [PW_W-1:0]   idx;
    logic [PW_W-1:0]   pw;
    logic              first;
    logic              new_event;
    logic              take;
    logic              last;
  } q_item_t;

endpackage

[design/ftpt_if.sv]
// Channel interfaces for the packet trigger extractor.
// Depends on ftpt_pkg.
interface ftpt_in_if import ftpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              first_of_packet;
  logic              last_of_packet;
  logic [PW_W-1:0]   packet_words;
  logic              new_event;
  modport source (output valid, word, first_of_packet, last_of_packet, packet_words,
                  new_event, input ready);
  modport sink   (input valid, word, first_of_packet, last_of_packet, packet_words,
                  new_event, output ready);
endinterface

interface ftpt_out_if import ftpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic              inner_found;
  logic [TRIG_W-1:0] inner_trigger;
  logic              outer_seen;
  logic [TRIG_W-1:0] outer_trigger;
  logic              trigger_mismatch;
  modport source (output valid, status, inner_found, inner_trigger, outer_seen,
                  outer_trigger, trigger_mismatch, input ready);
  modport sink   (input valid, status, inner_found, inner_trigger, outer_seen,
                  outer_trigger, trigger_mismatch, output ready);
endinterface

[design/ftpt_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module ftpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]              wdata,
  input  logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/ftpt_front.sv]
// Front end: takes input words, tracks the word index and drops idle words.
// Depends on ftpt_pkg, ftpt_if.
module ftpt_front import ftpt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  ftpt_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output q_item_t         q_data
);
  logic [PW_W-1:0] word_index, word_index_next;
  logic [PW_W-1:0] packet_length, packet_length_next;
  logic            acc;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    q_data.word      = in_ch.word;
    q_data.first     = in_ch.first_of_packet;
    q_data.new_event = in_ch.new_event;
    q_data.pw        = in_ch.packet_words;
    q_data.last      = in_ch.last_of_packet;
    if (in_ch.first_of_packet) begin
      q_data.idx         = '0;
      packet_length_next = in_ch.packet_words;
    end else begin
      q_data.idx         = word_index;
      packet_length_next = packet_length;
    end
    q_data.take     = q_data.idx < packet_length_next;
    word_index_next = q_data.take ? q_data.idx + 1'b1 : q_data.idx;
    // words past the packet end with no last mark carry nothing
    q_push = acc && (q_data.first || q_data.take || q_data.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index    <= '0;
      packet_length <= '0;
    end else if (acc) begin
      word_index    <= word_index_next;
      packet_length <= packet_length_next;
    end
  end
endmodule

[design/ftpt_queue.sv]
// Short FIFO between front end and back end.
// Depends on ftpt_pkg.
module ftpt_queue import ftpt_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output q_item_t head
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  q_item_t        slots [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;

  assign full  = count == (AW+1)'(DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

[design/ftpt_back.sv]
// Back end: packet parsing, frame walk over the length table and results.
// Depends on ftpt_pkg, ftpt_if, ftpt_ram.
module ftpt_back import ftpt_pkg::*; #(
  parameter int unsigned MAX_FRAMES       = MAX_FRAMES_DEF,
  parameter int unsigned MAX_PACKET_WORDS = MAX_PACKET_WORDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  q_item_t q_head,
  output logic    q_pop,
  ftpt_out_if.source out_ch
);
  localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

  back_state_t       state, state_next;
  logic [PW_W-1:0]   packet_length, packet_length_next;
  logic [CW-1:0]     frame_total, frame_total_next;
  logic [CW-1:0]     frame_cursor, frame_cursor_next;
  logic [NFW_W-1:0]  next_frame_word, next_frame_word_next;
  status_t           packet_status, packet_status_next;
  logic              packet_settled, packet_settled_next;
  logic              event_frozen, event_frozen_next;
  logic [VAL_W-1:0]  inner_value, inner_value_next;
  logic [VAL_W-1:0]  outer_value, outer_value_next;
  logic [WORD_W-1:0] cur_len, cur_len_next;
  logic              pend_last, pend_last_next;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] rdata;
  logic              emit, out_free;
  logic [3:0]        ftype;
  logic [PW_W:0]     idx_x;
  logic [CW-1:0]     cur_inc;

  ftpt_ram #(.WIDTH(WORD_W), .DEPTH(MAX_FRAMES)) u_len_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_head.word),
    .raddr (frame_cursor[AW-1:0]),
    .rdata (rdata)
  );

  assign out_free = !out_ch.valid || out_ch.ready;
  assign ftype    = q_head.word[30:27];
  assign idx_x    = {1'b0, q_head.idx};

  always_comb begin
    state_next           = state;
    packet_length_next   = packet_length;
    frame_total_next     = frame_total;
    frame_cursor_next    = frame_cursor;
    next_frame_word_next = next_frame_word;
    packet_status_next   = packet_status;
    packet_settled_next  = packet_settled;
    event_frozen_next    = event_frozen;
    inner_value_next     = inner_value;
    outer_value_next     = outer_value;
    cur_len_next         = cur_len;
    pend_last_next       = pend_last;
    we    = 1'b0;
    waddr = AW'(q_head.idx - 2'd2);
    emit  = 1'b0;
    q_pop = 1'b0;
    cur_inc = frame_cursor + 1'b1;
    unique case (state)
      BK_RUN: begin
        // only a packet end needs the result register free
        if (q_valid && (out_free || !q_head.last)) begin
          q_pop = 1'b1;
          if (q_head.first) begin
            if (q_head.new_event) begin
              inner_value_next  = NOT_SEEN;
              outer_value_next  = NOT_SEEN;
              event_frozen_next = 1'b0;
            end
            packet_length_next   = q_head.pw;
            frame_total_next     = '0;
            frame_cursor_next    = '0;
            next_frame_word_next = '0;
            packet_settled_next  = 1'b0;
            packet_status_next   = STAT_NONE;
            if (q_head.pw < PW_W'(2) ||
                {7'd0, q_head.pw} > 32'(MAX_PACKET_WORDS)) begin
              packet_settled_next = 1'b1;
              packet_status_next  = STAT_BAD_SZ;
            end
          end
          if (q_head.take && !packet_settled_next) begin
            if (q_head.idx == '0) begin
              if (q_head.word != MAGIC_BE && q_head.word != MAGIC_LE) begin
                packet_settled_next = 1'b1;
                packet_status_next  = STAT_BAD_MAG;
              end
            end else if (q_head.idx == PW_W'(1)) begin
              if (q_head.word > 32'(MAX_FRAMES)) begin
                packet_settled_next = 1'b1;
                packet_status_next  = STAT_BAD_CNT;
              end else begin
                frame_total_next     = CW'(q_head.word);
                frame_cursor_next    = '0;
                next_frame_word_next = NFW_W'(q_head.word) + NFW_W'(2);
                if (q_head.word == '0) begin
                  packet_settled_next = 1'b1;
                  packet_status_next  = STAT_NONE;
                end else if ((PW_W+1)'(q_head.word) + (PW_W+1)'(2) >
                             {1'b0, packet_length_next}) begin
                  packet_settled_next = 1'b1;
                  packet_status_next  = STAT_OVERRUN;
                end
              end
            end else if (idx_x < (PW_W+1)'(frame_total_next) + (PW_W+1)'(2)) begin
              // length table entry; the last one starts the walk
              we = 1'b1;
              if (idx_x == (PW_W+1)'(frame_total_next) + (PW_W+1)'(1)) begin
                state_next = BK_RD;
              end
            end else if (frame_cursor_next < frame_total_next &&
                         {2'b00, q_head.idx} == next_frame_word_next) begin
              if (ftype == TYPE_START_A || ftype == TYPE_START_B) begin
                if (!event_frozen_next) begin
                  inner_value_next  = {1'b0, q_head.word[TRIG_W-1:0]};
                  event_frozen_next = 1'b1;
                end
                packet_settled_next = 1'b1;
                packet_status_next  = STAT_FOUND;
              end else begin
                if (ftype == TYPE_HLT && !event_frozen_next) begin
                  outer_value_next = {1'b0, q_head.word[TRIG_W-1:0]};
                end
                next_frame_word_next = next_frame_word + NFW_W'(cur_len[WORD_W-1:2]);
                frame_cursor_next    = cur_inc;
                if (cur_inc < frame_total) begin
                  state_next = BK_RD;
                end else begin
                  packet_settled_next = 1'b1;
                  packet_status_next  = STAT_NONE;
                end
              end
            end
          end
          if (state_next == BK_RD) begin
            pend_last_next = q_head.last;
          end else begin
            emit = q_head.last;
          end
        end
      end
      BK_RD: begin
        state_next = BK_CHK;
      end
      BK_CHK: begin
        if (out_free || !pend_last) begin
          cur_len_next = rdata;
          state_next   = BK_RUN;
          if (rdata == '0 || rdata[WORD_W-1]) begin
            packet_settled_next = 1'b1;
            packet_status_next  = STAT_BAD_LEN;
          end else if (34'({next_frame_word, 2'b00}) + 34'(rdata) >
                       34'({packet_length, 2'b00})) begin
            packet_settled_next = 1'b1;
            packet_status_next  = STAT_OVERRUN;
          end else if (rdata[1:0] != 2'b00) begin
            // unaligned frame is skipped, length rounded up
            next_frame_word_next = next_frame_word + NFW_W'(rdata[WORD_W-1:2]) + NFW_W'(1);
            frame_cursor_next    = cur_inc;
            if (cur_inc < frame_total) begin
              state_next = BK_RD;
            end else begin
              packet_settled_next = 1'b1;
              packet_status_next  = STAT_NONE;
            end
          end
          if (state_next == BK_RUN) begin
            emit = pend_last;
          end
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BK_RUN;
      packet_length   <= '0;
      frame_total     <= '0;
      frame_cursor    <= '0;
      next_frame_word <= '0;
      packet_status   <= STAT_FOUND;
      packet_settled  <= 1'b0;
      event_frozen    <= 1'b0;
      inner_value     <= NOT_SEEN;
      outer_value     <= NOT_SEEN;
      pend_last       <= 1'b0;
      out_ch.valid    <= 1'b0;
    end else begin
      state           <= state_next;
      packet_length   <= packet_length_next;
      frame_total     <= frame_total_next;
      frame_cursor    <= frame_cursor_next;
      next_frame_word <= next_frame_word_next;
      packet_status   <= packet_status_next;
      packet_settled  <= packet_settled_next;
      event_frozen    <= event_frozen_next;
      inner_value     <= inner_value_next;
      outer_value     <= outer_value_next;
      pend_last       <= pend_last_next;
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
    cur_len <= cur_len_next;
    if (emit) begin
      out_ch.status           <= packet_settled_next ? packet_status_next : STAT_NONE;
      out_ch.inner_found      <= event_frozen_next;
      out_ch.inner_trigger    <= inner_value_next[TRIG_W-1:0];
      out_ch.outer_seen       <= !outer_value_next[TRIG_W];
      out_ch.outer_trigger    <= outer_value_next[TRIG_W-1:0];
      out_ch.trigger_mismatch <= inner_value_next[TRIG_W-1:0] !=
                                 outer_value_next[TRIG_W-1:0];
    end
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    frame_cursor <= frame_total)
    else $error("frame cursor past frame count");
  a_rd_to_chk: assert property (@(posedge clk) disable iff (rst)
    state == BK_RD |=> state == BK_CHK)
    else $error("table read not followed by check");
  a_no_pop_in_walk: assert property (@(posedge clk) disable iff (rst)
    state != BK_RUN |-> !q_pop)
    else $error("queue popped during frame walk");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwrote an untaken word");
endmodule

[design/frame_table_packet_trigger_extractor_core.sv]
// Packet trigger extractor top level: parses packets of 32-bit words and reports
// trigger numbers. Depends on ftpt_pkg, ftpt_if, ftpt_front, ftpt_queue, ftpt_back.
// Throughput: one word per cycle, except that the back end takes no word while the
// frame walk reads a length table entry, nor a packet end while the result waits.
// Result word is registered when the back end takes the last word, no walk pending.
// Synchronous reset clears control and trigger state but not the result word or cur_len.
module frame_table_packet_trigger_extractor_core import ftpt_pkg::*; #(
  parameter int unsigned MAX_FRAMES       = MAX_FRAMES_DEF,
  parameter int unsigned MAX_PACKET_WORDS = MAX_PACKET_WORDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  ftpt_in_if.sink    in_ch,
  ftpt_out_if.source out_ch
);
  // front to queue and queue to back end
  logic    q_push, q_full, q_pop, q_valid;
  q_item_t q_in, q_head;

  // front end: word index, packet length, drop of words with no effect
  ftpt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // four-word decoupling queue
  ftpt_queue #(.DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back end: header checks, length table, frame walk, result register
  ftpt_back #(
    .MAX_FRAMES       (MAX_FRAMES),
    .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule

[tb/sv/tb_frame_table_packet_trigger_extractor_core.sv]
`timescale 1ns / 100ps
// Testbench for frame_table_packet_trigger_extractor_core: packet words in, one
// trigger report word out per packet end. Depends on ftpt_pkg, ftpt_if and the core.
module tb_frame_table_packet_trigger_extractor_core;
  import ftpt_pkg::*;

  // one packet word as offered to the block
  typedef struct {
    logic [31:0] word;
    logic        first;
    logic        last;
    logic [24:0] pw;
    logic        new_event;
    logic        drain;      // hold back until every report has come
  } pkt_word_t;

  // one trigger report as the block should give it
  typedef struct {
    status_t     status;
    logic        inner_found;
    logic [15:0] inner_trigger;
    logic        outer_seen;
    logic [15:0] outer_trigger;
    logic        trigger_mismatch;
  } report_t;

  localparam int unsigned FRAMES_MAX  = 256;
  localparam int unsigned PKT_MAX     = 16 * 1024 * 1024;
  localparam int          LONG_HOLD   = 400;
  localparam int          QUIET_WORDS = 150;

  logic clk;
  logic rst;

  ftpt_in_if  in_ch ();
  ftpt_out_if out_ch ();

  frame_table_packet_trigger_extractor_core dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pkt_word_t word_q[$];    // words still to offer
  report_t   report_q[$];  // reports owed by the block
  int        fail_count = 0;
  int        reports_seen = 0;
  bit        quiet = 0;

  // ---------------------------------------------------------------------------
  // Parser state, mirrored in the testbench
  // ---------------------------------------------------------------------------
  logic [31:0] m_idx, m_plen, m_total, m_cursor, m_next, m_status;
  logic [31:0] m_lens [FRAMES_MAX];
  bit          m_settled, m_frozen;
  logic [16:0] m_inner, m_outer;

  function automatic void settle(logic [31:0] code);
    m_status  = code;
    m_settled = 1;
  endfunction

  // walk frames whose length is no multiple of 4 until one must be waited for
  function automatic void walk_frames();
    longint avail, off;
    logic [31:0] lo;
    avail = (longint'(m_plen) - 2 - longint'(m_total)) * 4;
    while (!m_settled && m_cursor < m_total) begin
      lo  = (m_cursor < FRAMES_MAX) ? m_lens[m_cursor] : 32'd0;
      off = (longint'(m_next) - 2 - longint'(m_total)) * 4;
      if (lo == 0 || lo[31]) begin
        settle(STAT_BAD_LEN);
        return;
      end
      if (off + longint'(lo) > avail) begin
        settle(STAT_OVERRUN);
        return;
      end
      if (lo[1:0] == 2'b00) return;
      m_next   = m_next + 32'((longint'(lo) + 3) >> 2);
      m_cursor = m_cursor + 1;
    end
    if (!m_settled) settle(STAT_NONE);
  endfunction

  function automatic void parse_word(logic [31:0] w, logic [31:0] idx);
    logic [3:0]  kind;
    logic [31:0] lo;
    if (idx == 0) begin
      if (w != MAGIC_BE && w != MAGIC_LE) settle(STAT_BAD_MAG);
      return;
    end
    if (idx == 1) begin
      if (w > FRAMES_MAX) begin
        settle(STAT_BAD_CNT);
        return;
      end
      m_total  = w;
      m_cursor = 0;
      m_next   = 2 + w;
      if (w == 0) settle(STAT_NONE);
      else if (longint'(w) + 2 > longint'(m_plen)) settle(STAT_OVERRUN);
      return;
    end
    if (idx < 2 + m_total) begin
      if (idx - 2 < FRAMES_MAX) m_lens[idx - 2] = w;
      if (idx == 1 + m_total) walk_frames();
      return;
    end
    if (m_cursor < m_total && idx == m_next) begin
      kind = w[30:27];
      lo   = (m_cursor < FRAMES_MAX) ? m_lens[m_cursor] : 32'd0;
      if (kind == TYPE_START_A || kind == TYPE_START_B) begin
        if (!m_frozen) begin
          m_inner  = {1'b0, w[15:0]};
          m_frozen = 1;
        end
        settle(STAT_FOUND);
        return;
      end
      if (kind == TYPE_HLT && !m_frozen) m_outer = {1'b0, w[15:0]};
      m_next   = m_next + (lo >> 2);
      m_cursor = m_cursor + 1;
      walk_frames();
    end
  endfunction

  // advance the mirror by one accepted word; queue a report on a packet end
  function automatic void predict_trigger_report(pkt_word_t p);
    report_t r;
    if (p.first) begin
      if (p.new_event) begin
        m_inner  = NOT_SEEN;
        m_outer  = NOT_SEEN;
        m_frozen = 0;
      end
      m_idx     = 0;
      m_plen    = 32'(p.pw);
      m_total   = 0;
      m_cursor  = 0;
      m_next    = 0;
      m_settled = 0;
      m_status  = STAT_NONE;
      if (p.pw < 2 || p.pw > PKT_MAX) settle(STAT_BAD_SZ);
    end
    if (m_idx < m_plen) begin
      if (!m_settled) parse_word(p.word, m_idx);
      m_idx = m_idx + 1;
    end
    if (!p.last) return;
    r.status           = m_settled ? status_t'(m_status[2:0]) : STAT_NONE;
    r.inner_found      = m_frozen;
    r.inner_trigger    = m_inner[15:0];
    r.outer_seen       = !m_outer[16];
    r.outer_trigger    = m_outer[15:0];
    r.trigger_mismatch = m_inner[15:0] != m_outer[15:0];
    report_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic add_word(logic [31:0] w, bit f, bit l, logic [24:0] pw, bit ne, bit dr);
    pkt_word_t p;
    p.word = w; p.first = f; p.last = l; p.pw = pw; p.new_event = ne; p.drain = dr;
    word_q.push_back(p);
  endtask

  // push a word list as one packet; pw and new_event matter on the first word only
  task automatic emit_packet(logic [31:0] ws[$], logic [24:0] pw, bit ne, bit dr);
    for (int i = 0; i < ws.size(); i++)
      add_word(ws[i], i == 0, i == ws.size() - 1,
               (i == 0) ? pw : 25'($urandom), (i == 0) ? ne : 1'($urandom), dr && i == 0);
  endtask

  function automatic logic [31:0] frame_head(logic [3:0] kind);
    logic [31:0] w;
    w = $urandom;
    w[30:27] = kind;
    return w;
  endfunction

  function automatic logic [3:0] pick_kind();
    case ($urandom_range(0, 6))
      0: return TYPE_START_A;
      1: return TYPE_START_B;
      2, 3: return TYPE_HLT;
      default: return 4'($urandom);
    endcase
  endfunction

  // flaw: 0 clean, 1 bad magic, 2 bad count, 3 zero length, 4 negative length,
  // 5 packet_words too short, 6 packet_words too long (packet cut short)
  task automatic send_packet(int nfr, bit ne, bit dr, int flaw);
    logic [31:0] ws[$];
    logic [31:0] lens[$];
    logic [31:0] len;
    int          pw;
    ws.push_back($urandom_range(0, 1) ? MAGIC_BE : MAGIC_LE);
    ws.push_back(nfr);
    for (int i = 0; i < nfr; i++) begin
      len = ($urandom_range(0, 9) < 7) ? 4 * $urandom_range(1, 5) : $urandom_range(1, 19);
      lens.push_back(len);
      ws.push_back(len);
    end
    for (int i = 0; i < nfr; i++)
      for (int j = 0; j < (lens[i] + 3) / 4; j++)
        ws.push_back(j == 0 ? frame_head(pick_kind()) : $urandom);
    pw = ws.size();
    case (flaw)
      1: ws[0] = $urandom;
      2: ws[1] = $urandom_range(0, 1) ? $urandom_range(FRAMES_MAX + 1, 4000) : $urandom | 32'h8000_0000;
      3: if (nfr > 0) ws[2 + $urandom_range(0, nfr - 1)] = 0;
      4: if (nfr > 0) ws[2 + $urandom_range(0, nfr - 1)] = $urandom | 32'h8000_0000;
      5: pw = $urandom_range(2, pw > 2 ? pw - 1 : 2);
      6: pw = pw + $urandom_range(1, 6);
      default: ;
    endcase
    emit_packet(ws, 25'(pw), ne, dr);
  endtask

  task automatic build_directed();
    logic [31:0] ws[$];
    // a packet end with no packet open
    add_word($urandom, 0, 1, 25'd5, 1, 0);
    // sizes below the minimum and above the maximum
    ws = '{MAGIC_BE, 32'd0};
    emit_packet(ws, 25'd0, 1, 0);
    emit_packet(ws, 25'd1, 0, 0);
    emit_packet(ws, 25'h1FF_FFFF, 0, 0);
    emit_packet(ws, 25'(PKT_MAX + 1), 0, 0);
    // largest legal size, cut short by the end flag
    ws = '{MAGIC_LE, 32'd1, 32'd8, frame_head(TYPE_HLT)};
    emit_packet(ws, 25'(PKT_MAX), 1, 0);
    // little-endian magic, zero frames
    ws = '{MAGIC_LE, 32'd0};
    emit_packet(ws, 25'd2, 0, 0);
    // bad magic, count just above the limit, count with top bit set
    ws = '{32'h0, 32'd0};
    emit_packet(ws, 25'd2, 0, 0);
    ws = '{MAGIC_BE, 32'(FRAMES_MAX + 1)};
    emit_packet(ws, 25'd2, 0, 0);
    ws = '{MAGIC_BE, 32'hFFFF_FFFF};
    emit_packet(ws, 25'd2, 0, 0);
    // table longer than the packet
    ws = '{MAGIC_BE, 32'd3, 32'd4};
    emit_packet(ws, 25'd3, 0, 0);
    // full table of 256 entries with no room for frames: overrun
    ws = '{MAGIC_BE, 32'(FRAMES_MAX)};
    for (int i = 0; i < FRAMES_MAX; i++) ws.push_back(32'd4);
    emit_packet(ws, 25'(FRAMES_MAX + 2), 0, 0);
    // zero and negative lengths
    ws = '{MAGIC_BE, 32'd1, 32'd0, 32'h0};
    emit_packet(ws, 25'd4, 0, 0);
    ws = '{MAGIC_BE, 32'd1, 32'h8000_0000, 32'h0};
    emit_packet(ws, 25'd4, 0, 0);
    // skipped odd frame, HLT frame, then start frame; trailing words ignored
    ws = '{MAGIC_BE, 32'd3, 32'd5, 32'd4, 32'd4, frame_head(TYPE_START_A), 32'h0,
           frame_head(TYPE_HLT), frame_head(TYPE_START_B), $urandom, $urandom};
    emit_packet(ws, 25'd9, 1, 0);
    // frozen event: a later start or HLT frame changes nothing
    ws = '{MAGIC_LE, 32'd2, 32'd4, 32'd4, frame_head(TYPE_HLT), frame_head(TYPE_START_A)};
    emit_packet(ws, 25'd6, 0, 1);
    // a packet restarted before its end
    add_word(MAGIC_BE, 1, 0, 25'd4, 1, 0);
    add_word(32'd1, 0, 0, 25'd0, 0, 0);
    ws = '{MAGIC_BE, 32'd1, 32'd4, frame_head(TYPE_HLT)};
    emit_packet(ws, 25'd4, 0, 0);
  endtask

  task automatic build_random(int target);
    int start;
    start = word_q.size();
    while (word_q.size() - start < target) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: words with no packet open, stray ends, wild sizes
        add_word($urandom, $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                 25'($urandom), 1'($urandom), 0);
      end else begin
        send_packet($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6),
                    $urandom_range(0, 2) == 0, $urandom_range(0, 14) == 0,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    rst = 1;
    in_ch.valid           = 0;
    in_ch.word            = '0;
    in_ch.first_of_packet = 0;
    in_ch.last_of_packet  = 0;
    in_ch.packet_words    = '0;
    in_ch.new_event       = 0;
    out_ch.ready          = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
  end

  // ---------------------------------------------------------------------------
  // Sender: a word leaves the queue on acceptance, the next one shows at the
  // falling edge; gaps start only when nothing is held on the channel
  // ---------------------------------------------------------------------------
  bit took = 0;
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      predict_trigger_report(word_q[0]);
      word_q.pop_front();
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      quiet = word_q.size() < QUIET_WORDS;
      if (in_ch.valid && !took) begin
        // word still on offer: leave it
      end else if (word_q.size() == 0) begin
        in_ch.valid <= 0;
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 0;
      end else if (word_q[0].drain && report_q.size() != 0) begin
        in_ch.valid <= 0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 13);
        in_ch.valid <= 0;
      end else begin
        in_ch.valid           <= 1;
        in_ch.word            <= word_q[0].word;
        in_ch.first_of_packet <= word_q[0].first;
        in_ch.last_of_packet  <= word_q[0].last;
        in_ch.packet_words    <= word_q[0].pw;
        in_ch.new_event       <= word_q[0].new_event;
      end
      took = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else if (!hold_done && reports_seen >= 15) begin
        hold_done = 1;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 13);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    report_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        report_mismatch("unexpected report word", out_ch.status, 0);
      end else begin
        e = report_q.pop_front();
        if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
        if (out_ch.inner_found !== e.inner_found)
          report_mismatch("inner_found", out_ch.inner_found, e.inner_found);
        if (out_ch.inner_trigger !== e.inner_trigger)
          report_mismatch("inner_trigger", out_ch.inner_trigger, e.inner_trigger);
        if (out_ch.outer_seen !== e.outer_seen)
          report_mismatch("outer_seen", out_ch.outer_seen, e.outer_seen);
        if (out_ch.outer_trigger !== e.outer_trigger)
          report_mismatch("outer_trigger", out_ch.outer_trigger, e.outer_trigger);
        if (out_ch.trigger_mismatch !== e.trigger_mismatch)
          report_mismatch("trigger_mismatch", out_ch.trigger_mismatch, e.trigger_mismatch);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    m_idx = 0; m_plen = 0; m_total = 0; m_cursor = 0; m_next = 0; m_status = 0;
    m_settled = 0; m_frozen = 0; m_inner = NOT_SEEN; m_outer = NOT_SEEN;
    for (int i = 0; i < FRAMES_MAX; i++) m_lens[i] = '0;
    build_directed();
    build_random(540);
    @(negedge rst);
    while (word_q.size() != 0 || report_q.size() != 0) @(posedge clk);
    // let any walk still in the back end finish before judging
    repeat (60) @(posedge clk);
    if (fail_count == 0 && report_q.size() == 0)
      $display("** frame_table_packet_trigger_extractor_core: PASSED **");
    else
      $display("** frame_table_packet_trigger_extractor_core: FAILED **");
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d words unsent, %0d reports owed", word_q.size(), report_q.size());
    $display("** frame_table_packet_trigger_extractor_core: FAILED **");
    $finish;
  end

endmodule
